/* src/crtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types and constants for the cartridge real-time clock: command and
// response beats, the time record and the register map codes.
// ----------------------------------------------------------------------------
package crtc_pkg;

    // command function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_LATCH = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // register map
    localparam logic [2:0] REG_SEC     = 3'd0;
    localparam logic [2:0] REG_MIN     = 3'd1;
    localparam logic [2:0] REG_HOUR    = 3'd2;
    localparam logic [2:0] REG_DAY_LO  = 3'd3;
    localparam logic [2:0] REG_DAY_HI  = 3'd4;

    // last value of each field before it rolls over with a carry
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [8:0] DAY_LAST  = 9'd511;

    // bit positions in the day high / flags register
    localparam int DAY8_BIT  = 0;
    localparam int HALT_BIT  = 6;
    localparam int CARRY_BIT = 7;

    typedef struct packed {
        logic       halt;
        logic       carry;
        logic [8:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } crtc_time_t;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] reg_index;
        logic [7:0] wr_data;
    } crtc_cmd_t;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       time_valid;
    } crtc_rsp_t;

endpackage

/* src/crtc_tick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtc_tick
// One-second advance of the live time: seconds, minutes, hours and days with
// cascaded carries, out-of-range fields wrap at field width without carry.
// ----------------------------------------------------------------------------
module crtc_tick
    import crtc_pkg::*;
(
    input  crtc_time_t cur,
    output crtc_time_t nxt
);

    // carry cascade, nothing moves while halted
    always_comb
    begin
        nxt = cur;
        if (!cur.halt)
        begin
            if (cur.sec != SEC_LAST)
            begin
                nxt.sec = cur.sec + 6'd1;
            end
            else
            begin
                nxt.sec = '0;
                if (cur.min != MIN_LAST)
                begin
                    nxt.min = cur.min + 6'd1;
                end
                else
                begin
                    nxt.min = '0;
                    if (cur.hour != HOUR_LAST)
                    begin
                        nxt.hour = cur.hour + 5'd1;
                    end
                    else
                    begin
                        nxt.hour = '0;
                        if (cur.day != DAY_LAST)
                        begin
                            nxt.day = cur.day + 9'd1;
                        end
                        else
                        begin
                            nxt.day   = '0;
                            nxt.carry = 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

/* src/cartridge_rtc_time_counter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_rtc_time_counter_top
// Cartridge real-time clock with live and latched time and a five-byte map.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one beat per event:
//   a one-second tick, a latch control write, a register write or a read.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one beat per
//   command: the latched register byte for reads (zero otherwise) and a flag
//   telling whether the latched time holds legal seconds, minutes, hours.
//   The response is in the output register on the edge after the command
//   beat. A new command is taken every cycle while cmd_stall is low; the
//   whole update is one pass of carry and mux logic from the state register.
//   While the receiver stalls, the response holds and cmd_stall is raised
//   only if that held response would otherwise be overwritten.
//   Reset: live time all zero and running with carry clear, latched time
//   zero, stored latch level one, no response pending.
// ----------------------------------------------------------------------------
module cartridge_rtc_time_counter_top
    import crtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  crtc_cmd_t  cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output crtc_rsp_t  rsp
);

    crtc_time_t live_reg;
    crtc_time_t live_next;
    crtc_time_t latched_reg;
    crtc_time_t latched_next;
    logic       level_reg;
    logic       level_next;
    crtc_time_t tick_time;
    logic       rsp_valid_reg;
    crtc_rsp_t  rsp_reg;
    crtc_rsp_t  rsp_next;
    logic       accept;

    // handshake
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // one-second advance
    crtc_tick u_tick (
        .cur (live_reg),
        .nxt (tick_time)
    );

    // command decode and state update
    always_comb
    begin
        live_next        = live_reg;
        latched_next     = latched_reg;
        level_next       = level_reg;
        rsp_next.rd_data = '0;
        case (cmd.func)
            FUNC_TICK:
            begin
                live_next = tick_time;
            end
            FUNC_LATCH:
            begin
                level_next = cmd.wr_data[0];
                if (!level_reg && cmd.wr_data[0])
                begin
                    latched_next = live_reg;
                end
            end
            FUNC_WRITE:
            begin
                case (cmd.reg_index)
                    REG_SEC:    live_next.sec      = cmd.wr_data[5:0];
                    REG_MIN:    live_next.min      = cmd.wr_data[5:0];
                    REG_HOUR:   live_next.hour     = cmd.wr_data[4:0];
                    REG_DAY_LO: live_next.day[7:0] = cmd.wr_data;
                    REG_DAY_HI:
                    begin
                        live_next.day[8] = cmd.wr_data[DAY8_BIT];
                        live_next.halt   = cmd.wr_data[HALT_BIT];
                        live_next.carry  = cmd.wr_data[CARRY_BIT];
                    end
                    default:
                    begin
                        live_next = live_reg;
                    end
                endcase
            end
            FUNC_READ:
            begin
                case (cmd.reg_index)
                    REG_SEC:    rsp_next.rd_data = {2'b00, latched_reg.sec};
                    REG_MIN:    rsp_next.rd_data = {2'b00, latched_reg.min};
                    REG_HOUR:   rsp_next.rd_data = {3'b000, latched_reg.hour};
                    REG_DAY_LO: rsp_next.rd_data = latched_reg.day[7:0];
                    REG_DAY_HI:
                    begin
                        rsp_next.rd_data = {latched_reg.carry, latched_reg.halt,
                                            5'b00000, latched_reg.day[8]};
                    end
                    default:
                    begin
                        rsp_next.rd_data = '0;
                    end
                endcase
            end
            default:
            begin
                live_next = live_reg;
            end
        endcase
        rsp_next.time_valid = (latched_next.sec <= SEC_LAST) &&
                              (latched_next.min <= MIN_LAST) &&
                              (latched_next.hour <= HOUR_LAST);
    end

    // clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            latched_reg <= '0;
            level_reg   <= 1'b1;
        end
        else if (accept)
        begin
            live_reg    <= live_next;
            latched_reg <= latched_next;
            level_reg   <= level_next;
        end
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // a halted clock ignores ticks
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.func == FUNC_TICK && live_reg.halt |=> $stable(live_reg))
        else $error("live time moved while halted");

    // latched copy changes only on a latch control beat
    a_latch_only: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && cmd.func == FUNC_LATCH) |=> $stable(latched_reg))
        else $error("latched time changed without latch beat");

    // carry rises only from a day wrap or a register write
    a_carry_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(live_reg.carry) |-> $past(accept && (cmd.func == FUNC_WRITE ||
            (cmd.func == FUNC_TICK && live_reg.day == DAY_LAST)))
        ) else $error("carry set without day wrap or write");

    // reads beyond the map return zero
    a_bad_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.func == FUNC_READ && cmd.reg_index > REG_DAY_HI
        |=> rsp_valid && rsp.rd_data == 8'd0)
        else $error("out-of-map read returned data");

    // a held response blocks new commands
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response lost");

endmodule
